@@ hdl/tiff_8bit_pixel_converter_macros.svh @@
// Assertion helpers for the converter blocks; only tpc_back uses them.
// Each expects clk and arst_n to be visible where it is used.
`ifndef TIFF_8BIT_PIXEL_CONVERTER_MACROS_SVH
`define TIFF_8BIT_PIXEL_CONVERTER_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define TPC_CHECK(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("tpc check failed");

// Property that must hold in the cycle after its trigger.
`define TPC_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpc sequence check failed");

`endif

@@ hdl/tpc_pkg.sv @@
`timescale 1ns / 1ps

package tpc_pkg;

	localparam int OFFSET_W    = 15;
	localparam int SIZE_W      = 16;
	localparam int POS_W       = 16;
	localparam int WORD_W      = 31;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Two quotient bits per cycle, eight bits per colour.
	localparam int DIV_STEPS   = 4;
	localparam int STEP_W      = $clog2(DIV_STEPS);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PHOTO_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_PRESENT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 3'd5;

	typedef enum logic [1:0] {
		PM_PALETTE  = 2'd0,
		PM_RGB      = 2'd1,
		PM_MINWHITE = 2'd2,
		PM_MINBLACK = 2'd3
	} photo_mode_t;

	typedef enum logic [1:0] {
		OP_PASS,
		OP_INVERT,
		OP_RGB,
		OP_RGBA
	} pix_op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic [7:0] sample_a;
		logic [7:0] sample_b;
		logic [7:0] sample_c;
		logic [7:0] sample_d;
	} pix_in_t;

	typedef struct packed {
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [WORD_W-1:0] pixel_word;
		logic              last_pixel;
	} pix_out_t;

	typedef struct packed {
		photo_mode_t         photo_mode;
		logic                alpha_present;
		logic [OFFSET_W-1:0] origin_x;
		logic [OFFSET_W-1:0] origin_y;
		logic [SIZE_W-1:0]   window_width;
		logic [SIZE_W-1:0]   window_height;
	} cfg_t;

	typedef struct packed {
		pix_op_t          op;
		pix_in_t          pix;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic             last;
	} q_entry_t;

endpackage

@@ hdl/tpc_front.sv @@
`timescale 1ns / 1ps

module tpc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  tpc_pkg::cfg_t    cfg,
	input  logic             px_valid,
	output logic             px_ready,
	input  tpc_pkg::pix_in_t px_data,
	input  logic             q_full,
	output logic             push,
	output tpc_pkg::q_entry_t push_data
);

	logic [tpc_pkg::OFFSET_W-1:0] col_q;
	logic [tpc_pkg::OFFSET_W-1:0] row_q;
	logic                         drop;
	tpc_pkg::pix_op_t             op;
	logic                         row_end;
	logic                         col_end;
	logic                         win_end;
	logic                         accept;

	// Classify by photometric mode; grey with alpha gives nothing.
	always_comb begin
		drop = 1'b0;
		op   = tpc_pkg::OP_PASS;
		case (cfg.photo_mode)
			tpc_pkg::PM_PALETTE: begin
				op = tpc_pkg::OP_PASS;
			end
			tpc_pkg::PM_RGB: begin
				op = cfg.alpha_present ? tpc_pkg::OP_RGBA : tpc_pkg::OP_RGB;
			end
			tpc_pkg::PM_MINWHITE: begin
				op   = tpc_pkg::OP_INVERT;
				drop = cfg.alpha_present;
			end
			tpc_pkg::PM_MINBLACK: begin
				op   = tpc_pkg::OP_PASS;
				drop = cfg.alpha_present;
			end
			default: begin
				op = tpc_pkg::OP_PASS;
			end
		endcase
	end

	// Saturated offsets end a row or the window regardless of size.
	assign col_end = (col_q == tpc_pkg::OFFSET_MAX) ||
		(({1'b0, col_q} + 16'd1) >= cfg.window_width);
	assign row_end = (row_q == tpc_pkg::OFFSET_MAX) ||
		(({1'b0, row_q} + 16'd1) >= cfg.window_height);
	assign win_end = col_end && row_end;

	assign px_ready = !q_full;
	assign accept   = px_valid && px_ready;
	assign push     = accept && !drop;

	always_comb begin
		push_data.op    = op;
		push_data.pix   = px_data;
		push_data.pos_x = {1'b0, cfg.origin_x} + {1'b0, col_q};
		push_data.pos_y = {1'b0, cfg.origin_y} + {1'b0, row_q};
		push_data.last  = win_end;
	end

	// Advance the raster walk on each produced pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (win_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_end) begin
				col_q <= '0;
				row_q <= row_q + 15'd1;
			end else begin
				col_q <= col_q + 15'd1;
			end
		end
	end

endmodule

@@ hdl/tpc_queue.sv @@
`timescale 1ns / 1ps

module tpc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tpc_pkg::q_entry_t push_data,
	output logic              full,
	input  logic              pop,
	output tpc_pkg::q_entry_t head,
	output logic              head_valid
);

	tpc_pkg::q_entry_t          ent_q [tpc_pkg::QUEUE_DEPTH];
	logic [tpc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [tpc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [tpc_pkg::QCNT_W-1:0] count_q;

	localparam logic [tpc_pkg::QPTR_W-1:0] PTR_LAST = tpc_pkg::QPTR_W'(tpc_pkg::QUEUE_DEPTH - 1);
	localparam logic [tpc_pkg::QCNT_W-1:0] CNT_FULL = tpc_pkg::QCNT_W'(tpc_pkg::QUEUE_DEPTH);

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/tpc_back.sv @@
`timescale 1ns / 1ps
`include "tiff_8bit_pixel_converter_macros.svh"

module tpc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tpc_pkg::q_entry_t  head,
	input  logic               head_valid,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_ready,
	output tpc_pkg::pix_out_t  res_data
);

	localparam int LANES = 3;
	localparam logic [tpc_pkg::STEP_W-1:0] STEP_LAST = tpc_pkg::STEP_W'(tpc_pkg::DIV_STEPS - 1);

	tpc_pkg::back_state_t       state_q;
	tpc_pkg::back_state_t       state_nx;
	logic [tpc_pkg::STEP_W-1:0] step_q;
	tpc_pkg::q_entry_t          ent_q;
	logic [7:0]                 alpha_q;
	logic [7:0]                 rem_q [LANES];
	logic [7:0]                 low_q [LANES];
	logic [7:0]                 quo_q [LANES];
	logic [7:0]                 rem_nx [LANES];
	logic [7:0]                 low_nx [LANES];
	logic [7:0]                 quo_nx [LANES];
	logic [7:0]                 head_col [LANES];
	logic [15:0]                head_num [LANES];
	logic                       needs_div;
	logic                       can_load;
	logic                       load_div;
	logic                       load_out;
	logic                       sel_div;
	logic [tpc_pkg::WORD_W-1:0] direct_word;
	logic [tpc_pkg::WORD_W-1:0] div_word;
	logic                       res_valid_q;
	tpc_pkg::pix_out_t          res_q;

	// One restoring step: returns {quotient bit, new remainder}.
	function automatic logic [8:0] div_step(input logic [7:0] r, input logic nb,
		input logic [7:0] dv);
		logic [8:0] t;
		logic [8:0] res;
		t = {r, nb};
		if (t >= {1'b0, dv}) begin
			res = {1'b1, 8'(t - {1'b0, dv})};
		end else begin
			res = {1'b0, t[7:0]};
		end
		return res;
	endfunction

	function automatic logic [6:0] alpha_byte(input logic [7:0] d);
		return 7'd127 - d[7:1];
	endfunction

	assign needs_div = (head.op == tpc_pkg::OP_RGBA) && (head.pix.sample_d != 8'd0);
	assign can_load  = !res_valid_q || res_ready;

	// Clamp colours to alpha and form colour*255 as (c << 8) - c.
	assign head_col[0] = (head.pix.sample_a > head.pix.sample_d) ? head.pix.sample_d : head.pix.sample_a;
	assign head_col[1] = (head.pix.sample_b > head.pix.sample_d) ? head.pix.sample_d : head.pix.sample_b;
	assign head_col[2] = (head.pix.sample_c > head.pix.sample_d) ? head.pix.sample_d : head.pix.sample_c;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			head_num[i] = {head_col[i], 8'd0} - {8'd0, head_col[i]};
		end
	end

	// Two quotient bits per lane per cycle.
	always_comb begin
		logic [8:0] s1;
		logic [8:0] s2;
		for (int i = 0; i < LANES; i++) begin
			s1        = div_step(rem_q[i], low_q[i][7], alpha_q);
			s2        = div_step(s1[7:0], low_q[i][6], alpha_q);
			rem_nx[i] = s2[7:0];
			quo_nx[i] = {quo_q[i][5:0], s1[8], s2[8]};
			low_nx[i] = {low_q[i][5:0], 2'b00};
		end
	end

	always_comb begin
		direct_word = '0;
		case (head.op)
			tpc_pkg::OP_PASS: begin
				direct_word = {23'd0, head.pix.sample_a};
			end
			tpc_pkg::OP_INVERT: begin
				direct_word = {23'd0, 8'd255 - head.pix.sample_a};
			end
			tpc_pkg::OP_RGB: begin
				direct_word = {7'd0, head.pix.sample_a, head.pix.sample_b, head.pix.sample_c};
			end
			tpc_pkg::OP_RGBA: begin
				// Zero alpha: colours clamp to zero.
				direct_word = {alpha_byte(head.pix.sample_d), 24'd0};
			end
			default: begin
				direct_word = '0;
			end
		endcase
	end

	assign div_word = {alpha_byte(alpha_q), quo_q[0], quo_q[1], quo_q[2]};

	always_comb begin
		state_nx = state_q;
		case (state_q)
			tpc_pkg::BK_IDLE: begin
				if (head_valid && needs_div) begin
					state_nx = tpc_pkg::BK_DIV;
				end
			end
			tpc_pkg::BK_DIV: begin
				if (step_q == STEP_LAST) begin
					state_nx = tpc_pkg::BK_DONE;
				end
			end
			tpc_pkg::BK_DONE: begin
				if (can_load) begin
					state_nx = tpc_pkg::BK_IDLE;
				end
			end
			default: begin
				state_nx = tpc_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		load_div = 1'b0;
		load_out = 1'b0;
		sel_div  = 1'b0;
		case (state_q)
			tpc_pkg::BK_IDLE: begin
				if (head_valid && needs_div) begin
					pop      = 1'b1;
					load_div = 1'b1;
				end else if (head_valid && can_load) begin
					pop      = 1'b1;
					load_out = 1'b1;
				end
			end
			tpc_pkg::BK_DONE: begin
				load_out = can_load;
				sel_div  = 1'b1;
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tpc_pkg::BK_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load_div) begin
				step_q <= '0;
			end else if (state_q == tpc_pkg::BK_DIV) begin
				step_q <= step_q + 1'b1;
			end
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_div) begin
			ent_q   <= head;
			alpha_q <= head.pix.sample_d;
			for (int i = 0; i < LANES; i++) begin
				rem_q[i] <= head_num[i][15:8];
				low_q[i] <= head_num[i][7:0];
				quo_q[i] <= '0;
			end
		end else if (state_q == tpc_pkg::BK_DIV) begin
			for (int i = 0; i < LANES; i++) begin
				rem_q[i] <= rem_nx[i];
				low_q[i] <= low_nx[i];
				quo_q[i] <= quo_nx[i];
			end
		end
		if (load_out) begin
			if (sel_div) begin
				res_q.pos_x      <= ent_q.pos_x;
				res_q.pos_y      <= ent_q.pos_y;
				res_q.pixel_word <= div_word;
				res_q.last_pixel <= ent_q.last;
			end else begin
				res_q.pos_x      <= head.pos_x;
				res_q.pos_y      <= head.pos_y;
				res_q.pixel_word <= direct_word;
				res_q.last_pixel <= head.last;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	`TPC_CHECK(a_pop_only_idle, !pop || state_q == tpc_pkg::BK_IDLE)
	`TPC_CHECK(a_no_overwrite, !(load_out && res_valid_q && !res_ready))
	`TPC_CHECK_NEXT(a_div_ends, state_q == tpc_pkg::BK_DIV && step_q == STEP_LAST, state_q == tpc_pkg::BK_DONE)
	`TPC_CHECK(a_rem_below_alpha, state_q != tpc_pkg::BK_DIV || (rem_q[0] < alpha_q && rem_q[1] < alpha_q && rem_q[2] < alpha_q))

endmodule

@@ hdl/tiff_8bit_pixel_converter.sv @@
// 8-bit TIFF pixel converter.
// Input channel px_valid/px_ready/px_data carries one pixel (four samples) per
// transfer; output channel res_valid/res_ready/res_data carries the window
// position, the 31-bit pixel word and the last-pixel flag. Grey modes with
// alpha consume the pixel and produce nothing.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle, and
// the user must write only while no pixel is in flight; no logic enforces it.
// Path: direct modes pass the queue entry and the result register; RGB with
// nonzero alpha also passes the divider states BK_DIV and BK_DONE.
// Throughput: one pixel per cycle for the direct modes while res_ready stays
// high; RGB with alpha holds the queue until the divider, which resolves two
// quotient bits per colour per cycle, has passed its result to the output.
// A two-entry queue separates the front (classify, place in window) from the
// back (convert), so the front keeps taking pixels while a result waits.
// When the receiver stalls, the result register holds, then the queue fills
// and px_ready drops.
// Reset clears the window walk, the queue and the result valid, and loads the
// register defaults (palette, no alpha, origin 0, 1 x 1 window).
`timescale 1ns / 1ps

module tiff_8bit_pixel_converter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tpc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               px_valid,
	output logic                               px_ready,
	input  tpc_pkg::pix_in_t                   px_data,
	output logic                               res_valid,
	input  logic                               res_ready,
	output tpc_pkg::pix_out_t                  res_data
);

	tpc_pkg::cfg_t     cfg_q;
	logic              q_full;
	logic              push;
	tpc_pkg::q_entry_t push_data;
	tpc_pkg::q_entry_t head;
	logic              head_valid;
	logic              pop;

	// Register file: drop bits above each register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.photo_mode    <= tpc_pkg::PM_PALETTE;
			cfg_q.alpha_present <= 1'b0;
			cfg_q.origin_x      <= '0;
			cfg_q.origin_y      <= '0;
			cfg_q.window_width  <= 16'd1;
			cfg_q.window_height <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				tpc_pkg::CFG_PHOTO_MODE: begin
					cfg_q.photo_mode <= tpc_pkg::photo_mode_t'(cfg_data[1:0]);
				end
				tpc_pkg::CFG_ALPHA_PRESENT: begin
					cfg_q.alpha_present <= cfg_data[0];
				end
				tpc_pkg::CFG_ORIGIN_X: begin
					cfg_q.origin_x <= cfg_data[14:0];
				end
				tpc_pkg::CFG_ORIGIN_Y: begin
					cfg_q.origin_y <= cfg_data[14:0];
				end
				tpc_pkg::CFG_WINDOW_WIDTH: begin
					cfg_q.window_width <= cfg_data;
				end
				tpc_pkg::CFG_WINDOW_HEIGHT: begin
					cfg_q.window_height <= cfg_data;
				end
				default: begin
					// Unmapped index: ignore the write.
				end
			endcase
		end
	end

	// Front: take the pixel, classify it, attach its window position.
	tpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.px_valid  (px_valid),
		.px_ready  (px_ready),
		.px_data   (px_data),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// Queue between front and back.
	tpc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// Back: form the pixel word, divide for un-premultiplied alpha, hold result.
	tpc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data)
	);

endmodule

@@ dv/tiff_8bit_pixel_converter_tb.sv @@
`timescale 1ns / 1ps

module tiff_8bit_pixel_converter_tb;

	// Settle time after the last expected result: covers the slowest path
	// (RGB with alpha) and pixels dropped in grey-with-alpha modes.
	localparam int SETTLE_CYCLES = 16;
	localparam int ITEMS_PER_PHASE = 600;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tpc_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           px_valid;
	logic                           px_ready;
	tpc_pkg::pix_in_t               px_data;
	logic                           res_valid;
	logic                           res_ready = 1'b0;
	tpc_pkg::pix_out_t              res_data;

	// Shadow of the block's registers and window walk.
	tpc_pkg::cfg_t                  shadow_cfg;
	logic [tpc_pkg::OFFSET_W-1:0]   col_pos;
	logic [tpc_pkg::OFFSET_W-1:0]   row_pos;

	// Converted pixels still owed by the block, oldest first.
	tpc_pkg::pix_out_t              pending_pixels[$];

	int                             mismatch_count = 0;
	int                             send_idle_pct = 0;
	int                             recv_idle_pct = 0;

	tiff_8bit_pixel_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.px_valid  (px_valid),
		.px_ready  (px_ready),
		.px_data   (px_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs or stops producing results.
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// A row or window ends on its last offset, or once the 15-bit offset
	// saturates for sizes above 32768. Size zero acts as one.
	function automatic bit offset_at_end(input logic [tpc_pkg::OFFSET_W-1:0] off,
	                                     input logic [tpc_pkg::SIZE_W-1:0] size);
		return (off == tpc_pkg::OFFSET_MAX) || (int'(off) + 1 >= int'(size));
	endfunction

	// Clamp the color to alpha, then scale back up by 255/alpha, truncating.
	// Zero alpha leaves the (clamped, hence zero) color alone.
	function automatic logic [7:0] unpremultiply(input logic [7:0] color,
	                                             input logic [7:0] alpha);
		int unsigned c;
		c = (color > alpha) ? 32'(alpha) : 32'(color);
		if (alpha != 8'd0)
			c = c * 255 / alpha;
		return c[7:0];
	endfunction

	// Convert one pixel and advance the window walk. Returns 0 when the
	// mode drops the pixel (grey with alpha); the walk holds in that case.
	function automatic bit convert_pixel(input tpc_pkg::pix_in_t p,
	                                     output tpc_pkg::pix_out_t r);
		logic [tpc_pkg::WORD_W-1:0] word;
		logic [7:0]                 alpha_byte;
		bit                         row_done;
		bit                         window_done;
		r = '0;
		case (shadow_cfg.photo_mode)
			tpc_pkg::PM_RGB: begin
				if (shadow_cfg.alpha_present) begin
					alpha_byte = 8'd127 - (p.sample_d >> 1);
					word = {alpha_byte[6:0],
						unpremultiply(p.sample_a, p.sample_d),
						unpremultiply(p.sample_b, p.sample_d),
						unpremultiply(p.sample_c, p.sample_d)};
				end else begin
					word = {7'd0, p.sample_a, p.sample_b, p.sample_c};
				end
			end
			tpc_pkg::PM_MINWHITE: begin
				if (shadow_cfg.alpha_present)
					return 1'b0;
				word = {23'd0, 8'd255 - p.sample_a};
			end
			tpc_pkg::PM_MINBLACK: begin
				if (shadow_cfg.alpha_present)
					return 1'b0;
				word = {23'd0, p.sample_a};
			end
			default: begin
				// palette ignores alpha_present
				word = {23'd0, p.sample_a};
			end
		endcase

		row_done = offset_at_end(col_pos, shadow_cfg.window_width);
		window_done = row_done && offset_at_end(row_pos, shadow_cfg.window_height);

		r.pos_x = {1'b0, shadow_cfg.origin_x} + {1'b0, col_pos};
		r.pos_y = {1'b0, shadow_cfg.origin_y} + {1'b0, row_pos};
		r.pixel_word = word;
		r.last_pixel = window_done;

		if (window_done) begin
			col_pos = '0;
			row_pos = '0;
		end else if (row_done) begin
			col_pos = '0;
			row_pos = row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Result side: random stall and per-field compare
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic flag_mismatch(input string what, input logic [31:0] want,
	                             input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %0s mismatch, expected %h got %h", $realtime, what, want, got);
	endtask

	// Compare every result transfer against the oldest pending pixel.
	always @(posedge clk) begin
		tpc_pkg::pix_out_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_pixels.size() == 0) begin
				flag_mismatch("unexpected result", 32'd0, 32'(res_data.pixel_word));
			end else begin
				want = pending_pixels.pop_front();
				if (res_data.pos_x !== want.pos_x)
					flag_mismatch("pos_x", 32'(want.pos_x), 32'(res_data.pos_x));
				if (res_data.pos_y !== want.pos_y)
					flag_mismatch("pos_y", 32'(want.pos_y), 32'(res_data.pos_y));
				if (res_data.pixel_word !== want.pixel_word)
					flag_mismatch("pixel_word", 32'(want.pixel_word),
						32'(res_data.pixel_word));
				if (res_data.last_pixel !== want.last_pixel)
					flag_mismatch("last_pixel", 32'(want.last_pixel),
						32'(res_data.last_pixel));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Wait until every owed pixel is back, then let dropped pixels clear.
	task automatic wait_idle();
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Hold cfg_we high across back-to-back writes; the caller drops it.
	task automatic write_reg(input logic [tpc_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			tpc_pkg::CFG_PHOTO_MODE:
				shadow_cfg.photo_mode = tpc_pkg::photo_mode_t'(val[1:0]);
			tpc_pkg::CFG_ALPHA_PRESENT: shadow_cfg.alpha_present = val[0];
			tpc_pkg::CFG_ORIGIN_X:
				shadow_cfg.origin_x = val[tpc_pkg::OFFSET_W-1:0];
			tpc_pkg::CFG_ORIGIN_Y:
				shadow_cfg.origin_y = val[tpc_pkg::OFFSET_W-1:0];
			tpc_pkg::CFG_WINDOW_WIDTH:  shadow_cfg.window_width = val;
			tpc_pkg::CFG_WINDOW_HEIGHT: shadow_cfg.window_height = val;
			default: ;
		endcase
	endtask

	// Rewrite all six registers. The window walk is kept across this.
	task automatic configure(input logic [15:0] mode, input logic [15:0] alpha,
	                         input logic [15:0] ox, input logic [15:0] oy,
	                         input logic [15:0] width, input logic [15:0] height);
		wait_idle();
		write_reg(tpc_pkg::CFG_PHOTO_MODE, mode);
		write_reg(tpc_pkg::CFG_ALPHA_PRESENT, alpha);
		write_reg(tpc_pkg::CFG_ORIGIN_X, ox);
		write_reg(tpc_pkg::CFG_ORIGIN_Y, oy);
		write_reg(tpc_pkg::CFG_WINDOW_WIDTH, width);
		write_reg(tpc_pkg::CFG_WINDOW_HEIGHT, height);
		cfg_we <= 1'b0;
	endtask

	// Present one pixel and hold it until the transfer. Valid stays high on
	// return so a following pixel goes out back to back; it only drops at an
	// idle gap or at the end of a burst.
	task automatic send_pixel(input tpc_pkg::pix_in_t p, output bit produced);
		tpc_pkg::pix_out_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			px_valid <= 1'b0;
			@(posedge clk);
		end
		px_valid <= 1'b1;
		px_data <= p;
		produced = convert_pixel(p, r);
		if (produced)
			pending_pixels.push_back(r);
		@(posedge clk);
		while (!px_ready)
			@(posedge clk);
	endtask

	task automatic send_burst(input tpc_pkg::pix_in_t pixels[$]);
		bit produced;
		foreach (pixels[i])
			send_pixel(pixels[i], produced);
		px_valid <= 1'b0;
		wait_idle();
	endtask

	// Random samples, biased toward the alpha corner cases.
	function automatic tpc_pkg::pix_in_t random_pixel();
		tpc_pkg::pix_in_t p;
		p = $urandom;
		case ($urandom_range(0, 9))
			0: p.sample_d = 8'd0;
			1: p.sample_d = 8'hFF;
			2: begin
				p.sample_d = 8'($urandom_range(1, 255));
				p.sample_b = p.sample_d;
			end
			3: p = '1;
			4: p = '0;
			default: ;
		endcase
		return p;
	endfunction

	task automatic send_random_burst(input int count);
		bit produced;
		repeat (count) begin
			send_pixel(random_pixel(), produced);
		end
		px_valid <= 1'b0;
		wait_idle();
	endtask

	// Mostly tiny windows so rows and windows end often; now and then zero,
	// exactly 32768, the 16-bit maximum or anything at all.
	function automatic logic [15:0] pick_size();
		case ($urandom_range(0, 19))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic logic [15:0] pick_origin();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'h7FFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Out of reset: palette, 1 x 1 window at the origin, so every pixel is last.
	task automatic test_reset_defaults();
		tpc_pkg::pix_in_t pixels[$];
		pixels.push_back({8'h00, 8'h00, 8'h00, 8'h00});
		pixels.push_back({8'hFF, 8'hFF, 8'hFF, 8'hFF});
		send_burst(pixels);
	endtask

	// Palette at the far origin; alpha_present must not matter here.
	task automatic test_palette_window();
		tpc_pkg::pix_in_t pixels[$];
		configure(16'(tpc_pkg::PM_PALETTE), 16'd1, 16'h7FFF, 16'h7FFF, 16'd2, 16'd2);
		pixels.push_back({8'h00, 8'hFF, 8'h00, 8'hFF});
		pixels.push_back({8'hFF, 8'h00, 8'hFF, 8'h00});
		pixels.push_back({8'h80, 8'h55, 8'hAA, 8'h01});
		pixels.push_back({8'h7F, 8'hAA, 8'h55, 8'h80});
		send_burst(pixels);
	endtask

	// Inversion and pass-through, then both grey modes with alpha: those
	// pixels vanish and the walk must not move.
	task automatic test_grey_modes();
		tpc_pkg::pix_in_t pixels[$];
		configure(16'(tpc_pkg::PM_MINWHITE), 16'd0, 16'd3, 16'd4, 16'd4, 16'd2);
		pixels = {32'h00FFFFFF, 32'hFF000000};
		send_burst(pixels);
		configure(16'(tpc_pkg::PM_MINBLACK), 16'd0, 16'd3, 16'd4, 16'd4, 16'd2);
		pixels = {32'hA5123456};
		send_burst(pixels);
		configure(16'(tpc_pkg::PM_MINWHITE), 16'd1, 16'd3, 16'd4, 16'd4, 16'd2);
		pixels = {32'h11223344};
		send_burst(pixels);
		configure(16'(tpc_pkg::PM_MINBLACK), 16'd1, 16'd3, 16'd4, 16'd4, 16'd2);
		pixels = {32'h55667788};
		send_burst(pixels);
		configure(16'(tpc_pkg::PM_PALETTE), 16'd0, 16'd3, 16'd4, 16'd4, 16'd2);
		pixels = {32'h3C000000};
		send_burst(pixels);
	endtask

	// Packed RGB, then un-premultiply with zero, full, tiny and mid alpha,
	// colors above alpha included.
	task automatic test_rgb();
		tpc_pkg::pix_in_t pixels[$];
		configure(16'(tpc_pkg::PM_RGB), 16'd0, 16'd5, 16'd9, 16'd2, 16'd2);
		pixels = {32'hFF00FF00, 32'h00FF00FF};
		send_burst(pixels);
		configure(16'(tpc_pkg::PM_RGB), 16'd1, 16'd5, 16'd9, 16'd2, 16'd2);
		pixels = {32'hFFFFFF00, 32'hFFFFFFFF, 32'hFF800001, 32'h407F8080, 32'h123456FE};
		send_burst(pixels);
	endtask

	// Zero width and zero height act as one.
	task automatic test_degenerate_sizes();
		tpc_pkg::pix_in_t pixels[$];
		configure(16'(tpc_pkg::PM_PALETTE), 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		pixels = {32'h01000000, 32'h02000000};
		send_burst(pixels);
		configure(16'(tpc_pkg::PM_PALETTE), 16'd0, 16'd0, 16'd0, 16'd0, 16'd3);
		pixels = {32'h03000000, 32'h04000000};
		send_burst(pixels);
	endtask

	// Shrink the window under the walk: the current row, then the whole
	// window, ends on the next pixel.
	task automatic test_resize_mid_window();
		tpc_pkg::pix_in_t pixels[$];
		configure(16'(tpc_pkg::PM_PALETTE), 16'd0, 16'd10, 16'd20, 16'd8, 16'd4);
		pixels = {32'h10000000, 32'h11000000, 32'h12000000};
		send_burst(pixels);
		configure(16'(tpc_pkg::PM_PALETTE), 16'd0, 16'd10, 16'd20, 16'd2, 16'd4);
		pixels = {32'h13000000};
		send_burst(pixels);
		configure(16'(tpc_pkg::PM_PALETTE), 16'd0, 16'd10, 16'd20, 16'd1, 16'd1);
		pixels = {32'h14000000};
		send_burst(pixels);
	endtask

	// Random settings and bursts until enough pixels have gone out.
	// Settings change between bursts, often in the middle of a window.
	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		int total;
		int burst_len;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		total = 0;
		while (total < ITEMS_PER_PHASE) begin
			configure(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				pick_origin(), pick_origin(), pick_size(), pick_size());
			burst_len = $urandom_range(1, 40);
			send_random_burst(burst_len);
			total += burst_len;
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= tpc_pkg::CFG_PHOTO_MODE;
		cfg_data <= '0;
		px_valid <= 1'b0;
		px_data <= '0;

		// Register defaults after reset.
		shadow_cfg.photo_mode = tpc_pkg::PM_PALETTE;
		shadow_cfg.alpha_present = 1'b0;
		shadow_cfg.origin_x = '0;
		shadow_cfg.origin_y = '0;
		shadow_cfg.window_width = 16'd1;
		shadow_cfg.window_height = 16'd1;
		col_pos = '0;
		row_pos = '0;

		send_idle_pct = 7;
		recv_idle_pct = 53;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_palette_window();
		test_grey_modes();
		test_rgb();
		test_degenerate_sizes();
		test_resize_mid_window();
		test_random_traffic(7, 53);
		test_random_traffic(53, 7);
		test_random_traffic(0, 0);

		wait_idle();
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/tpc_pkg.sv
hdl/tpc_front.sv
hdl/tpc_queue.sv
hdl/tpc_back.sv
hdl/tiff_8bit_pixel_converter.sv
dv/tiff_8bit_pixel_converter_tb.sv
